FILE: rtl/core/pud_pkg.sv
// ----------------------------------------------------------------------------
// pud_pkg
// Shared types and constants for the percent url decoder.
// ----------------------------------------------------------------------------
package pud_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam int MAX_BYTES = 3;
  localparam int CNT_W     = 2;

  // one input word
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } pud_in_t;

  // one result word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
  } pud_out_t;

  // classified work handed from front to back
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0]          cnt;
    logic                      last;
  } pud_cmd_t;

endpackage

FILE: rtl/core/percent_url_decoder_top.sv
// ----------------------------------------------------------------------------
// percent_url_decoder_top
// Streaming url percent decoder with queue-style ports on both sides.
// ----------------------------------------------------------------------------
// One encoded byte is taken per cycle while full is low. The front end turns
// each word into zero to three decoded bytes in the same cycle and stores
// any nonempty set as one command in a QDEPTH-entry queue; the back end
// emits one decoded byte per cycle while the result is popped or empty,
// from the queue head through a result register, so a word that decodes
// to n bytes holds the back end for n bytes. Full rises only when the
// queue has filled behind a slow consumer or a run of malformed escapes.
// A taken word passes through a queue slot and then the result register.
module percent_url_decoder_top #(
  parameter int QDEPTH = pud_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  pud_pkg::pud_in_t  item,
  output logic              empty,
  input  logic              pop,
  output pud_pkg::pud_out_t result
);

  logic              enq;
  logic              deq;
  logic              q_empty;
  pud_pkg::pud_cmd_t cmd;
  pud_pkg::pud_cmd_t head;

  pud_front u_front (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .item (item),
    .enq  (enq),
    .cmd  (cmd)
  );

  pud_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .enq   (enq),
    .wdata (cmd),
    .full  (full),
    .deq   (deq),
    .head  (head),
    .empty (q_empty)
  );

  pud_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (head),
    .q_deq   (deq),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

FILE: rtl/core/pud_front.sv
// ----------------------------------------------------------------------------
// pud_front
// Accepts encoded bytes, tracks the escape state and builds the list of
// decoded bytes that each input word produces.
// ----------------------------------------------------------------------------
module pud_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              full,
  input  pud_pkg::pud_in_t  item,
  output logic              enq,
  output pud_pkg::pud_cmd_t cmd
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_PCT  = 2'd1;
  localparam logic [1:0] PH_DIG  = 2'd2;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;

  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [7:0] held;
  logic [7:0] held_next;

  logic       accept;
  logic       b_hex;
  logic [3:0] b_nib;
  logic       h_hex;
  logic [3:0] h_nib;
  logic       do_idle;
  logic [1:0] n;
  logic [pud_pkg::MAX_BYTES-1:0][7:0] bytes;

  function automatic logic is_hex(input logic [7:0] c);
    logic r;
    r = (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    return r;
  endfunction

  // letters carry their value minus 9 in the low nibble
  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    logic [3:0] r;
    if (c inside {[8'h30:8'h39]}) begin
      r = c[3:0];
    end else begin
      r = c[3:0] + 4'd9;
    end
    return r;
  endfunction

  assign accept = push && !full;
  assign b_hex  = is_hex(item.in_byte);
  assign b_nib  = hex_nib(item.in_byte);
  assign h_hex  = is_hex(held);
  assign h_nib  = h_hex ? hex_nib(held) : 4'd0;

  always_comb begin
    phase_next = phase;
    held_next  = held;
    do_idle    = 1'b0;
    n          = 2'd0;
    bytes      = '0;

    case (phase)
      PH_PCT: begin
        if (b_hex) begin
          held_next  = item.in_byte;
          phase_next = PH_DIG;
        end else begin
          bytes[0]   = CH_PCT;
          n          = 2'd1;
          phase_next = PH_IDLE;
          do_idle    = 1'b1;
        end
      end
      PH_DIG: begin
        if (b_hex) begin
          bytes[0] = {h_nib, b_nib};
          n        = 2'd1;
        end else begin
          bytes[0] = CH_PCT;
          bytes[1] = held;
          n        = 2'd2;
          do_idle  = 1'b1;
        end
        phase_next = PH_IDLE;
        held_next  = '0;
      end
      default: begin
        phase_next = PH_IDLE;
        do_idle    = 1'b1;
      end
    endcase

    if (do_idle) begin
      if (item.in_byte == CH_PLUS) begin
        bytes[n] = CH_SPACE;
        n        = n + 2'd1;
      end else if (item.in_byte == CH_PCT) begin
        phase_next = PH_PCT;
      end else begin
        bytes[n] = item.in_byte;
        n        = n + 2'd1;
      end
    end

    // flush a pending escape at the end of the string
    if (item.in_last) begin
      if (phase_next == PH_PCT) begin
        bytes[n] = CH_PCT;
        n        = n + 2'd1;
      end else if (phase_next == PH_DIG) begin
        bytes[n]             = CH_PCT;
        bytes[n + 2'd1]      = held_next;
        n                    = n + 2'd2;
      end
      phase_next = PH_IDLE;
      held_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      held  <= '0;
    end else if (accept) begin
      phase <= phase_next;
      held  <= held_next;
    end
  end

  assign enq       = accept && (n != 2'd0);
  assign cmd.bytes = bytes;
  assign cmd.cnt   = n;
  assign cmd.last  = item.in_last;

endmodule

FILE: rtl/core/pud_queue.sv
// ----------------------------------------------------------------------------
// pud_queue
// Small circular queue of decode commands between front and back.
// ----------------------------------------------------------------------------
module pud_queue #(
  parameter int QDEPTH = pud_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              enq,
  input  pud_pkg::pud_cmd_t wdata,
  output logic              full,
  input  logic              deq,
  output pud_pkg::pud_cmd_t head,
  output logic              empty
);

  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(QDEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(QDEPTH);

  pud_pkg::pud_cmd_t slots [QDEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;

  logic do_enq;
  logic do_deq;

  assign full   = (count == DEPTH_C);
  assign empty  = (count == '0);
  assign do_enq = enq && !full;
  assign do_deq = deq && !empty;
  assign head   = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_enq) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_enq) begin
        wptr <= (wptr == LAST_IDX) ? '0 : wptr + AW'(1);
      end
      if (do_deq) begin
        rptr <= (rptr == LAST_IDX) ? '0 : rptr + AW'(1);
      end
      if (do_enq && !do_deq) begin
        count <= count + CW'(1);
      end else if (do_deq && !do_enq) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/core/pud_back.sv
// ----------------------------------------------------------------------------
// pud_back
// Walks the head command's bytes into the result register, one per cycle
// while it is empty or popped; tags the last byte of each word and string.
// ----------------------------------------------------------------------------
module pud_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  pud_pkg::pud_cmd_t q_head,
  output logic              q_deq,
  output logic              empty,
  input  logic              pop,
  output pud_pkg::pud_out_t result
);

  logic                        ovalid;
  pud_pkg::pud_out_t           oreg;
  logic [pud_pkg::CNT_W-1:0]   idx;
  logic                        load;
  logic                        at_end;
  logic [7:0]                  sel;

  always_comb begin
    case (idx)
      2'd0:    sel = q_head.bytes[0];
      2'd1:    sel = q_head.bytes[1];
      2'd2:    sel = q_head.bytes[2];
      default: sel = q_head.bytes[0];
    endcase
  end

  assign load   = !q_empty && (!ovalid || pop);
  assign at_end = (idx + 2'd1 == q_head.cnt);
  assign q_deq  = load && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      idx    <= '0;
    end else begin
      if (load) begin
        ovalid <= 1'b1;
        idx    <= at_end ? '0 : idx + 2'd1;
      end else if (pop) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      oreg.out_byte   <= sel;
      oreg.run_last   <= at_end;
      oreg.string_end <= at_end && q_head.last;
    end
  end

  assign empty  = !ovalid;
  assign result = oreg;

endmodule
